// ===== design/lbm_pkg.sv =====
// Shared types and constants of the Lucas binomial block.
package lbm_pkg;

    localparam int MOD_W   = 17;
    localparam int FIELD_W = 62;
    localparam int DVD_W   = 63;
    localparam int CNT_W   = 6;
    localparam int PROD_W  = 2 * MOD_W;

    localparam logic [CNT_W-1:0] NBITS_PROD = CNT_W'(PROD_W);
    localparam logic [CNT_W-1:0] NBITS_BOT  = CNT_W'(FIELD_W);
    localparam logic [CNT_W-1:0] NBITS_TOP  = CNT_W'(DVD_W);

    localparam logic REG_MODULUS = 1'b0;
    localparam logic CMD_PLAIN   = 1'b0;
    localparam logic CMD_MULTI   = 1'b1;

    localparam logic [MOD_W-1:0] MOD_RESET = MOD_W'(2);

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [CNT_W-1:0] nbits;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quot;
        logic [MOD_W-1:0] rem;
    } t_div_rsp;

    typedef struct packed {
        logic             wr;
        logic [MOD_W-1:0] modulus;
    } t_cfg;

endpackage

// ===== design/lbm_if.sv =====
// Query and result channel interfaces of the Lucas binomial block.
interface lbm_req_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [61:0] top_count;
    logic [61:0] bottom_count;

    modport source(output valid, command, top_count, bottom_count, input ready);
    modport sink(input valid, command, top_count, bottom_count, output ready);
endinterface

interface lbm_rsp_if;
    logic        valid;
    logic        ready;
    logic [16:0] coefficient;

    modport source(output valid, coefficient, input ready);
    modport sink(input valid, coefficient, output ready);
endinterface

// ===== design/lbm_divider.sv =====
// Shared restoring divider: one quotient bit per cycle, divisor is the modulus.
module lbm_divider (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [lbm_pkg::MOD_W-1:0]       i_divisor,
    input  lbm_pkg::t_div_req               i_req,
    output lbm_pkg::t_div_rsp               o_rsp
);

    logic                          r_busy, n_busy;
    logic                          r_done, n_done;
    logic [lbm_pkg::CNT_W-1:0]     r_cnt, n_cnt;
    logic [lbm_pkg::DVD_W-1:0]     r_dvd, n_dvd;
    logic [lbm_pkg::DVD_W-1:0]     r_quo, n_quo;
    logic [lbm_pkg::MOD_W-1:0]     r_rem, n_rem;

    logic                          s_bit;
    logic [lbm_pkg::MOD_W:0]       s_sh;
    logic [lbm_pkg::MOD_W:0]       s_sub;
    logic                          s_ge;

    always_comb begin
        s_bit = r_dvd[r_cnt - lbm_pkg::CNT_W'(1)];
        s_sh  = {r_rem, s_bit};
        s_ge  = s_sh >= {1'b0, i_divisor};
        s_sub = s_sh - {1'b0, i_divisor};

        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_dvd  = r_dvd;
        n_quo  = r_quo;
        n_rem  = r_rem;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = i_req.nbits;
            n_dvd  = i_req.dividend;
            n_quo  = '0;
            n_rem  = '0;
        end else if (r_busy) begin
            n_rem = s_ge ? s_sub[lbm_pkg::MOD_W-1:0] : s_sh[lbm_pkg::MOD_W-1:0];
            n_quo = {r_quo[lbm_pkg::DVD_W-2:0], s_ge};
            n_cnt = r_cnt - lbm_pkg::CNT_W'(1);
            if (r_cnt == lbm_pkg::CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_dvd <= n_dvd;
        r_quo <= n_quo;
        r_rem <= n_rem;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;
    assign o_rsp.rem  = r_rem;

endmodule

// ===== design/lbm_cfg.sv =====
// APB register file holding the modulus.
module lbm_cfg (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output lbm_pkg::t_cfg         o_cfg
);

    logic [lbm_pkg::MOD_W-1:0] r_mod, n_mod;
    logic                      s_wr;

    assign pready = 1'b1;
    assign s_wr   = psel && penable && pwrite && (paddr[2] == lbm_pkg::REG_MODULUS);

    always_comb begin
        n_mod = r_mod;
        if (s_wr) begin
            n_mod = pwdata[lbm_pkg::MOD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod <= lbm_pkg::MOD_RESET;
        end else begin
            r_mod <= n_mod;
        end
    end

    assign prdata = (paddr[2] == lbm_pkg::REG_MODULUS) ?
                    {{(32 - lbm_pkg::MOD_W){1'b0}}, r_mod} : 32'd0;

    assign o_cfg.wr      = s_wr;
    assign o_cfg.modulus = r_mod;

endmodule

// ===== design/lucas_binomial_mod_prime.sv =====
// Binomial coefficients modulo a configured prime p by Lucas's theorem. One query is taken at a
// time; the block is busy until its result has been placed in the output register. All arithmetic
// runs through one shared restoring divider (one bit per cycle) fed by a 17x17 multiplier. A query
// needs digit extraction plus 3 modular products per base-p digit of the bottom count, and stops
// early when the running product reaches zero or a bottom digit exceeds its top digit. The first
// query after reset or after a modulus write first rebuilds the factorial tables. A modulus below
// two or above TABLE_DEPTH gives a coefficient of zero.
module lucas_binomial_mod_prime #(
    parameter int TABLE_DEPTH = 131072
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lbm_req_if.sink       i_req,
    lbm_rsp_if.source     o_rsp,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int MW = lbm_pkg::MOD_W;

    typedef enum logic [25:0] {
        S_IDLE = 26'd1 << 0,
        S_CHK  = 26'd1 << 1,
        S_B0   = 26'd1 << 2,
        S_B1   = 26'd1 << 3,
        S_B2   = 26'd1 << 4,
        S_P1   = 26'd1 << 5,
        S_P2   = 26'd1 << 6,
        S_P3   = 26'd1 << 7,
        S_P4   = 26'd1 << 8,
        S_I1   = 26'd1 << 9,
        S_I2   = 26'd1 << 10,
        S_Q0   = 26'd1 << 11,
        S_Q1   = 26'd1 << 12,
        S_QB   = 26'd1 << 13,
        S_QT   = 26'd1 << 14,
        S_QW   = 26'd1 << 15,
        S_D1   = 26'd1 << 16,
        S_D2   = 26'd1 << 17,
        S_D3   = 26'd1 << 18,
        S_D4   = 26'd1 << 19,
        S_D5   = 26'd1 << 20,
        S_D6   = 26'd1 << 21,
        S_D7   = 26'd1 << 22,
        S_MUL  = 26'd1 << 23,
        S_WAIT = 26'd1 << 24,
        S_DONE = 26'd1 << 25
    } t_state;

    t_state r_state, n_state;
    t_state r_ret, n_ret;

    logic                         r_tab_ok, n_tab_ok;
    logic                         r_ovalid, n_ovalid;
    logic [MW-1:0]                r_ocoef, n_ocoef;
    logic                         r_cmd, n_cmd;
    logic [lbm_pkg::DVD_W-1:0]    r_top, n_top;
    logic [lbm_pkg::FIELD_W-1:0]  r_bot, n_bot;
    logic [MW-1:0]                r_acc, n_acc;
    logic [MW-1:0]                r_i, n_i;
    logic [MW-1:0]                r_base, n_base;
    logic [MW-1:0]                r_pres, n_pres;
    logic [MW-1:0]                r_e, n_e;
    logic [MW-1:0]                r_ma, n_ma;
    logic [MW-1:0]                r_mb, n_mb;
    logic [MW-1:0]                r_mres, n_mres;
    logic [MW-1:0]                r_res, n_res;
    logic [MW-1:0]                r_a, n_a;
    logic [MW-1:0]                r_b, n_b;

    logic [MW-1:0]                r_fact_mem [TABLE_DEPTH];
    logic [MW-1:0]                r_inv_mem  [TABLE_DEPTH];
    logic [MW-1:0]                r_fq;
    logic [MW-1:0]                r_iq;

    logic                         s_fwe, s_iwe;
    logic [AW-1:0]                s_fwaddr, s_iwaddr, s_iraddr;
    logic [MW-1:0]                s_fwdata, s_iwdata;
    logic [lbm_pkg::PROD_W-1:0]   s_prod;
    logic                         s_p_bad;

    lbm_pkg::t_cfg                s_cfg;
    lbm_pkg::t_div_req            s_div_req;
    lbm_pkg::t_div_rsp            s_div_rsp;

    lbm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (s_cfg)
    );

    lbm_divider u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_divisor (s_cfg.modulus),
        .i_req     (s_div_req),
        .o_rsp     (s_div_rsp)
    );

    assign s_prod  = r_ma * r_mb;
    assign s_p_bad = (s_cfg.modulus < MW'(2)) || (32'(s_cfg.modulus) > 32'(TABLE_DEPTH));

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = r_ovalid;
    assign o_rsp.coefficient = r_ocoef;

    always_comb begin
        n_state  = r_state;
        n_ret    = r_ret;
        n_tab_ok = r_tab_ok;
        n_ovalid = r_ovalid;
        n_ocoef  = r_ocoef;
        n_cmd    = r_cmd;
        n_top    = r_top;
        n_bot    = r_bot;
        n_acc    = r_acc;
        n_i      = r_i;
        n_base   = r_base;
        n_pres   = r_pres;
        n_e      = r_e;
        n_ma     = r_ma;
        n_mb     = r_mb;
        n_mres   = r_mres;
        n_res    = r_res;
        n_a      = r_a;
        n_b      = r_b;

        s_fwe    = 1'b0;
        s_fwaddr = AW'(r_i);
        s_fwdata = r_mres;
        s_iwe    = 1'b0;
        s_iwaddr = AW'(MW'(r_i - MW'(1)));
        s_iwdata = r_mres;
        s_iraddr = AW'(r_a);

        s_div_req.start    = 1'b0;
        s_div_req.dividend = {{(lbm_pkg::DVD_W - lbm_pkg::PROD_W){1'b0}}, s_prod};
        s_div_req.nbits    = lbm_pkg::NBITS_PROD;

        // drop the result once the sink has taken it
        if (r_ovalid && o_rsp.ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_cmd   = i_req.command;
                    n_top   = {1'b0, i_req.top_count};
                    n_bot   = i_req.bottom_count;
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (s_p_bad) begin
                    n_res   = '0;
                    n_state = S_DONE;
                end else if (!r_tab_ok) begin
                    n_state = S_B0;
                end else begin
                    n_state = S_Q0;
                end
            end
            S_B0: begin
                s_fwe    = 1'b1;
                s_fwaddr = '0;
                s_fwdata = MW'(1);
                n_acc    = MW'(1);
                n_i      = MW'(1);
                n_state  = S_B1;
            end
            S_B1: begin
                if (r_i < s_cfg.modulus) begin
                    n_ma    = r_acc;
                    n_mb    = r_i;
                    n_ret   = S_B2;
                    n_state = S_MUL;
                end else begin
                    // acc holds (p-1)!; raise it to p-2
                    n_base  = r_acc;
                    n_pres  = MW'(1);
                    n_e     = MW'(s_cfg.modulus - MW'(2));
                    n_state = S_P1;
                end
            end
            S_B2: begin
                s_fwe   = 1'b1;
                n_acc   = r_mres;
                n_i     = MW'(r_i + MW'(1));
                n_state = S_B1;
            end
            S_P1: begin
                if (r_e == '0) begin
                    s_iwe    = 1'b1;
                    s_iwaddr = AW'(MW'(s_cfg.modulus - MW'(1)));
                    s_iwdata = r_pres;
                    n_acc    = r_pres;
                    n_i      = MW'(s_cfg.modulus - MW'(1));
                    n_state  = S_I1;
                end else if (r_e[0]) begin
                    n_ma    = r_pres;
                    n_mb    = r_base;
                    n_ret   = S_P2;
                    n_state = S_MUL;
                end else begin
                    n_state = S_P3;
                end
            end
            S_P2: begin
                n_pres  = r_mres;
                n_state = S_P3;
            end
            S_P3: begin
                n_ma    = r_base;
                n_mb    = r_base;
                n_ret   = S_P4;
                n_state = S_MUL;
            end
            S_P4: begin
                n_base  = r_mres;
                n_e     = r_e >> 1;
                n_state = S_P1;
            end
            S_I1: begin
                if (r_i != '0) begin
                    n_ma    = r_acc;
                    n_mb    = r_i;
                    n_ret   = S_I2;
                    n_state = S_MUL;
                end else begin
                    n_tab_ok = 1'b1;
                    n_state  = S_Q0;
                end
            end
            S_I2: begin
                s_iwe   = 1'b1;
                n_acc   = r_mres;
                n_i     = MW'(r_i - MW'(1));
                n_state = S_I1;
            end
            S_Q0: begin
                n_res = MW'(1);
                if (r_cmd == lbm_pkg::CMD_MULTI) begin
                    if (r_bot == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_top   = r_top + {1'b0, r_bot} - lbm_pkg::DVD_W'(1);
                        n_state = S_Q1;
                    end
                end else begin
                    n_state = S_Q1;
                end
            end
            S_Q1: begin
                if (r_bot == '0) begin
                    n_state = S_DONE;
                end else begin
                    s_div_req.start    = 1'b1;
                    s_div_req.dividend = {1'b0, r_bot};
                    s_div_req.nbits    = lbm_pkg::NBITS_BOT;
                    n_state            = S_QB;
                end
            end
            S_QB: begin
                if (s_div_rsp.done) begin
                    n_a     = s_div_rsp.rem;
                    n_bot   = s_div_rsp.quot[lbm_pkg::FIELD_W-1:0];
                    n_state = S_QT;
                end
            end
            S_QT: begin
                s_div_req.start    = 1'b1;
                s_div_req.dividend = r_top;
                s_div_req.nbits    = lbm_pkg::NBITS_TOP;
                n_state            = S_QW;
            end
            S_QW: begin
                if (s_div_rsp.done) begin
                    n_b     = s_div_rsp.rem;
                    n_top   = s_div_rsp.quot;
                    n_state = S_D1;
                end
            end
            S_D1: begin
                // bottom digit above top digit: whole coefficient is zero
                if (r_a > r_b) begin
                    n_res   = '0;
                    n_state = S_DONE;
                end else begin
                    n_state = S_D2;
                end
            end
            S_D2: begin
                n_ma    = r_res;
                n_mb    = r_fq;
                n_ret   = S_D3;
                n_state = S_MUL;
            end
            S_D3: begin
                n_res   = r_mres;
                n_state = S_D4;
            end
            S_D4: begin
                n_ma    = r_res;
                n_mb    = r_iq;
                n_ret   = S_D5;
                n_state = S_MUL;
            end
            S_D5: begin
                s_iraddr = AW'(MW'(r_b - r_a));
                n_res    = r_mres;
                n_state  = S_D6;
            end
            S_D6: begin
                n_ma    = r_res;
                n_mb    = r_iq;
                n_ret   = S_D7;
                n_state = S_MUL;
            end
            S_D7: begin
                n_res   = r_mres;
                n_state = (r_mres == '0) ? S_DONE : S_Q1;
            end
            S_MUL: begin
                s_div_req.start = 1'b1;
                n_state         = S_WAIT;
            end
            S_WAIT: begin
                if (s_div_rsp.done) begin
                    n_mres  = s_div_rsp.rem;
                    n_state = r_ret;
                end
            end
            S_DONE: begin
                // hold until the output register is free
                if (!r_ovalid || o_rsp.ready) begin
                    n_ovalid = 1'b1;
                    n_ocoef  = r_res;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (s_cfg.wr) begin
            n_tab_ok = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ret    <= S_IDLE;
            r_tab_ok <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ret    <= n_ret;
            r_tab_ok <= n_tab_ok;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ocoef <= n_ocoef;
        r_cmd   <= n_cmd;
        r_top   <= n_top;
        r_bot   <= n_bot;
        r_acc   <= n_acc;
        r_i     <= n_i;
        r_base  <= n_base;
        r_pres  <= n_pres;
        r_e     <= n_e;
        r_ma    <= n_ma;
        r_mb    <= n_mb;
        r_mres  <= n_mres;
        r_res   <= n_res;
        r_a     <= n_a;
        r_b     <= n_b;
    end

    always_ff @(posedge i_clk) begin
        if (s_fwe) begin
            r_fact_mem[s_fwaddr] <= s_fwdata;
        end
        r_fq <= r_fact_mem[AW'(r_b)];
    end

    always_ff @(posedge i_clk) begin
        if (s_iwe) begin
            r_inv_mem[s_iwaddr] <= s_iwdata;
        end
        r_iq <= r_inv_mem[s_iraddr];
    end

    a_div_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_div_rsp.done |-> (r_state == S_WAIT || r_state == S_QB || r_state == S_QW))
        else $error("divider finished with no operation pending");

    a_cfg_clears_tables: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cfg.wr |=> !r_tab_ok)
        else $error("tables still marked ready after modulus write");

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("sequencer state not one-hot");

endmodule
